### sv/pfla_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page free-list allocator.
// No dependencies; every other file of the block refers to this package.
package pfla_pkg;

    localparam int NUM_PAGES_DEF  = 4096;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int ADDR_W    = 32;
    localparam int TOP_W     = 25;
    localparam int COUNT_W   = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHYS_TOP    = 1'd1;
    localparam logic [TOP_W-1:0]     PHYS_TOP_RESET  = 25'd16777216;

    typedef enum logic [1:0] {
        ACT_FREE  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_RANGE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] page_addr;
        logic [ADDR_W-1:0] range_end;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  result_addr;
        logic [1:0]         status;
        logic [COUNT_W-1:0] pages_added;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic rd_en;
        logic push;
        logic pop;
        logic set_bad;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic page_ok;
        logic range_more;
    } dp_stat_t;

endpackage

### sv/page_free_list_allocator.sv
`timescale 1ns / 1ps
// Page free-list allocator, top level. Depends on pfla_pkg, pfla_ctrl and pfla_dp.
// A free or allocate beat passes through its work state and S_DONE before its result
// is registered; a range beat pushes one page per cycle through the link memory write
// port until the range ends or a page fails the check. A new beat is taken only in
// idle or in S_DONE once the output is free. Asynchronous active-low reset empties the
// list and loads the register defaults; the link memory is not cleared.
module page_free_list_allocator #(
    parameter int NUM_PAGES  = pfla_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pfla_pkg::PAGE_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pfla_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfla_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pfla_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pfla_pkg::out_item_t            out_item
);

    // The controller decides what happens in each cycle; the datapath holds the
    // list head, the link memory, the per-beat working registers and the output
    // register. The output register lets a new beat be accepted in the cycle the
    // previous result moves out.
    pfla_pkg::cmd_t     cmd;
    pfla_pkg::dp_stat_t stat;

    pfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_action (in_item.action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // PAGE_BYTES and NUM_PAGES set the page offset and page number widths, and
    // the link memory depth. The page size is taken to be a power of two.
    pfla_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_item)
    );

endmodule

### sv/pfla_dp.sv
`timescale 1ns / 1ps
// Datapath of the page free-list allocator: registers, page check and link memory.
// Depends on pfla_pkg.
module pfla_dp #(
    parameter int NUM_PAGES  = pfla_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pfla_pkg::PAGE_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfla_pkg::CFG_W-1:0]       cfg_data,
    input  pfla_pkg::in_item_t               in_item,
    input  pfla_pkg::cmd_t                   cmd,
    output pfla_pkg::dp_stat_t               stat,
    output pfla_pkg::out_item_t              out_item
);

    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int PN_W   = $clog2(NUM_PAGES);
    localparam int LINK_W = PN_W + 1;
    localparam logic [32:0] OFF_MASK    = 33'(PAGE_BYTES - 1);
    localparam logic [32:0] PAGE_STEP   = 33'(PAGE_BYTES);
    localparam logic [32:0] NUM_PAGES_W = 33'(NUM_PAGES);

    logic [31:0]                 kernel_base_reg;
    logic [pfla_pkg::TOP_W-1:0]  phys_top_reg;
    logic                        head_valid_reg;
    logic [PN_W-1:0]             head_page_reg;
    logic [32:0]                 p_reg;
    logic [31:0]                 end_reg;
    logic [pfla_pkg::COUNT_W-1:0] cnt_reg;
    logic [1:0]                  res_status_reg;
    logic [31:0]                 res_addr_reg;
    pfla_pkg::out_item_t         out_item_reg;
    logic [LINK_W-1:0]           link_rd_reg;
    logic [LINK_W-1:0]           link_mem [NUM_PAGES];

    logic [31:0]     phys;
    logic [32:0]     pn_wide;
    logic [PN_W-1:0] pn;
    logic            aligned;
    logic [31:0]     pop_addr;
    logic [32:0]     start_up;

    always_comb
    begin
        phys     = p_reg[31:0] - kernel_base_reg;
        pn_wide  = 33'(phys >> OFF_W);
        pn       = PN_W'(phys >> OFF_W);
        aligned  = (p_reg[31:0] & OFF_MASK[31:0]) == 32'd0;
        pop_addr = kernel_base_reg + (32'(head_page_reg) << OFF_W);
        start_up = (33'(in_item.page_addr) + OFF_MASK) & ~OFF_MASK;

        stat.page_ok    = aligned && (phys < 32'(phys_top_reg)) && (pn_wide < NUM_PAGES_W);
        stat.range_more = ({1'b0, p_reg} + {1'b0, PAGE_STEP}) <= {2'b00, end_reg};
    end

    assign out_item = out_item_reg;

    // Configuration and list head.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_base_reg <= '0;
            phys_top_reg    <= pfla_pkg::PHYS_TOP_RESET;
            head_valid_reg  <= 1'b0;
            head_page_reg   <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == pfla_pkg::REG_KERNEL_BASE)
            begin
                kernel_base_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == pfla_pkg::REG_PHYS_TOP)
            begin
                phys_top_reg <= cfg_data[pfla_pkg::TOP_W-1:0];
            end
            if (cmd.push)
            begin
                head_valid_reg <= 1'b1;
                head_page_reg  <= pn;
            end
            else if (cmd.pop && head_valid_reg)
            begin
                head_valid_reg <= link_rd_reg[PN_W];
                head_page_reg  <= link_rd_reg[PN_W-1:0];
            end
        end
    end

    // Per-item working registers and the result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            if (pfla_pkg::action_t'(in_item.action) == pfla_pkg::ACT_RANGE)
            begin
                p_reg <= start_up;
            end
            else
            begin
                p_reg <= {1'b0, in_item.page_addr};
            end
            end_reg        <= in_item.range_end;
            cnt_reg        <= '0;
            res_status_reg <= pfla_pkg::ST_OK;
            res_addr_reg   <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                p_reg <= p_reg + PAGE_STEP;
                if (cnt_reg != '1)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.set_bad)
            begin
                res_status_reg <= pfla_pkg::ST_BAD;
            end
            if (cmd.pop)
            begin
                if (head_valid_reg)
                begin
                    res_addr_reg <= pop_addr;
                end
                else
                begin
                    res_status_reg <= pfla_pkg::ST_EMPTY;
                end
            end
        end
        if (cmd.load_out)
        begin
            out_item_reg.result_addr <= res_addr_reg;
            out_item_reg.status      <= res_status_reg;
            out_item_reg.pages_added <= cnt_reg;
        end
    end

    // Link memory: one write port for pushes, one registered read for pops.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            link_mem[pn] <= {head_valid_reg, head_page_reg};
        end
        if (cmd.rd_en)
        begin
            link_rd_reg <= link_mem[head_page_reg];
        end
    end

`ifndef ASSERT_OFF
    a_push_sets_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> head_valid_reg && head_page_reg == $past(pn))
        else $error("push did not update the list head");

    a_push_only_ok_page: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> stat.page_ok)
        else $error("push of a page that failed the check");
`endif

endmodule

### sv/pfla_ctrl.sv
`timescale 1ns / 1ps
// Controller of the page free-list allocator: sequencing and channel handshakes.
// Depends on pfla_pkg.
module pfla_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         in_action,
    output logic               out_valid,
    input  logic               out_stall,
    input  pfla_pkg::dp_stat_t stat,
    output pfla_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_ALLOC,
        S_RANGE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        in_stall   = !(state_reg == S_IDLE || (state_reg == S_DONE && out_free));
        accept     = in_valid && !in_stall;
        cmd        = '0;
        state_next = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_FREE:
            begin
                if (stat.page_ok)
                begin
                    cmd.push = 1'b1;
                end
                else
                begin
                    cmd.set_bad = 1'b1;
                end
                state_next = S_DONE;
            end
            S_ALLOC:
            begin
                cmd.pop    = 1'b1;
                state_next = S_DONE;
            end
            S_RANGE:
            begin
                if (!stat.range_more)
                begin
                    state_next = S_DONE;
                end
                else if (!stat.page_ok)
                begin
                    cmd.set_bad = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.push = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (accept)
        begin
            cmd.load_item = 1'b1;
            unique case (pfla_pkg::action_t'(in_action))
                pfla_pkg::ACT_FREE:
                begin
                    state_next = S_FREE;
                end
                pfla_pkg::ACT_ALLOC:
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_ALLOC;
                end
                pfla_pkg::ACT_RANGE:
                begin
                    state_next = S_RANGE;
                end
                default:
                begin
                    state_next = S_DONE;
                end
            endcase
        end

        out_valid_next = cmd.load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared without a finished item");

    a_single_step_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE || state_reg == S_ALLOC) |=> state_reg == S_DONE)
        else $error("single free or allocate took more than one work cycle");
`endif

endmodule

### tb/tb_page_free_list_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_free_list_allocator: directed and random beats
// against a free-list predictor. Depends on pfla_pkg and the allocator RTL only.
module tb_page_free_list_allocator;

    localparam int          FL_PAGES       = pfla_pkg::NUM_PAGES_DEF;
    localparam int          FL_PAGE_BYTES  = pfla_pkg::PAGE_BYTES_DEF;
    localparam int          PN_W           = $clog2(FL_PAGES);
    localparam int          AW             = pfla_pkg::ADDR_W;
    localparam int          TW             = pfla_pkg::TOP_W;
    localparam logic [1:0]  ACT_UNUSED     = 2'd3;
    localparam int          DRAIN_CYCLES   = 8;
    // The limit must outlast a full-memory range walk, during which nothing is accepted.
    localparam int          WATCHDOG_LIMIT = 20000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [pfla_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pfla_pkg::CFG_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    pfla_pkg::in_item_t             in_item;
    logic                           out_valid;
    logic                           out_stall;
    pfla_pkg::out_item_t            out_item;

    page_free_list_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Predictor state: the free list and the register copies.
    logic              fl_head_valid;
    logic [PN_W-1:0]   fl_head_page;
    logic              fl_link_valid [FL_PAGES];
    logic [PN_W-1:0]   fl_link_page  [FL_PAGES];
    logic [AW-1:0]     cfg_kernel_base;
    logic [TW-1:0]     cfg_phys_top;

    // Window of valid page addresses under the current settings, for stimulus.
    logic [AW-1:0]     win_base;
    int unsigned       good_pages;

    pfla_pkg::out_item_t pending_results[$];
    int          send_gap_pct;
    int          recv_stall_pct;
    int          errors;
    int          quiet_cycles;
    int unsigned n_beats;
    int unsigned n_results;
    int unsigned n_empty;
    int unsigned n_bad;
    int unsigned n_pushed;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Checks an address and gives its physical page number when it may go on the list.
    function automatic bit page_lookup(input logic [AW-1:0] vaddr,
                                       output logic [PN_W-1:0] pn);
        logic [AW-1:0] phys;
        phys = vaddr - cfg_kernel_base;
        pn   = '0;
        if (vaddr % FL_PAGE_BYTES != 0)
            return 1'b0;
        if (phys >= AW'(cfg_phys_top))
            return 1'b0;
        if (phys / FL_PAGE_BYTES >= FL_PAGES)
            return 1'b0;
        pn = PN_W'(phys / FL_PAGE_BYTES);
        return 1'b1;
    endfunction

    function automatic void push_free_page(input logic [PN_W-1:0] pn);
        fl_link_valid[pn] = fl_head_valid;
        fl_link_page[pn]  = fl_head_page;
        fl_head_valid     = 1'b1;
        fl_head_page      = pn;
    endfunction

    // Applies one beat to the predicted free list and returns the result it must give.
    function automatic pfla_pkg::out_item_t free_list_apply(input pfla_pkg::in_item_t item);
        pfla_pkg::out_item_t res;
        logic [PN_W-1:0]     pn;
        logic [AW:0]         walk_addr;
        logic [AW:0]         walk_end;
        res = '0;
        case (item.action)
            pfla_pkg::ACT_FREE:
            begin
                if (page_lookup(item.page_addr, pn))
                begin
                    push_free_page(pn);
                    res.pages_added = pfla_pkg::COUNT_W'(1);
                end
                else
                begin
                    res.status = pfla_pkg::ST_BAD;
                end
            end
            pfla_pkg::ACT_ALLOC:
            begin
                if (fl_head_valid)
                begin
                    res.result_addr = cfg_kernel_base
                                      + AW'(fl_head_page) * FL_PAGE_BYTES;
                    pn              = fl_head_page;
                    fl_head_valid   = fl_link_valid[pn];
                    fl_head_page    = fl_link_page[pn];
                end
                else
                begin
                    res.status = pfla_pkg::ST_EMPTY;
                end
            end
            pfla_pkg::ACT_RANGE:
            begin
                // One bit wider than an address, so the walk never wraps at the top.
                walk_addr = ({1'b0, item.page_addr} + (AW+1)'(FL_PAGE_BYTES - 1))
                            & ~(AW+1)'(FL_PAGE_BYTES - 1);
                walk_end  = {1'b0, item.range_end};
                while (walk_addr + (AW+1)'(FL_PAGE_BYTES) <= walk_end)
                begin
                    if (!page_lookup(walk_addr[AW-1:0], pn))
                    begin
                        res.status = pfla_pkg::ST_BAD;
                        break;
                    end
                    push_free_page(pn);
                    if (res.pages_added != '1)
                        res.pages_added = res.pages_added + 1'b1;
                    walk_addr = walk_addr + (AW+1)'(FL_PAGE_BYTES);
                end
            end
            default:
            begin
                // The unused code leaves the list alone and answers with zeros.
            end
        endcase
        return res;
    endfunction

    task automatic send_item(input pfla_pkg::in_item_t item);
        pfla_pkg::out_item_t want;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        want = free_list_apply(item);
        pending_results.push_back(want);
        n_beats++;
        n_pushed += want.pages_added;
        if (want.status == pfla_pkg::ST_EMPTY)
            n_empty++;
        if (want.status == pfla_pkg::ST_BAD)
            n_bad++;
    endtask

    task automatic send_beat(input logic [1:0] action, input logic [AW-1:0] addr,
                             input logic [AW-1:0] range_end);
        pfla_pkg::in_item_t item;
        item.action    = action;
        item.page_addr = addr;
        item.range_end = range_end;
        send_item(item);
    endtask

    // Lowers valid, waits for every predicted result, then lets the block settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Registers change only while the block is idle; both are written back to back.
    task automatic reconfigure(input logic [AW-1:0] base, input logic [TW-1:0] top);
        logic [AW-1:0] off;
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= pfla_pkg::REG_KERNEL_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= pfla_pkg::REG_PHYS_TOP;
        cfg_data  <= pfla_pkg::CFG_W'(top);
        @(posedge clk);
        cfg_we          <= 1'b0;
        cfg_kernel_base  = base;
        cfg_phys_top     = top;
        win_base         = (base + AW'(FL_PAGE_BYTES - 1))
                           & ~AW'(FL_PAGE_BYTES - 1);
        off              = win_base - base;
        if (AW'(top) > off)
            good_pages = (AW'(top) - off + FL_PAGE_BYTES - 1) / FL_PAGE_BYTES;
        else
            good_pages = 0;
        if (good_pages > FL_PAGES)
            good_pages = FL_PAGES;
    endtask

    // Mostly well-formed traffic inside the valid window, with some noise.
    function automatic pfla_pkg::in_item_t random_beat();
        pfla_pkg::in_item_t item;
        int unsigned        pick;
        int unsigned        k;
        int unsigned        span;
        pick           = $urandom_range(99);
        k              = (good_pages > 0) ? $urandom_range(good_pages - 1) : 0;
        item.action    = pfla_pkg::ACT_FREE;
        item.page_addr = win_base + k * FL_PAGE_BYTES;
        item.range_end = $urandom;
        if (pick < 30)
        begin
            // A good single page, as given.
        end
        else if (pick < 65)
        begin
            item.action    = pfla_pkg::ACT_ALLOC;
            item.page_addr = $urandom;
        end
        else if (pick < 80)
        begin
            span        = $urandom_range(6);
            item.action = pfla_pkg::ACT_RANGE;
            if ($urandom_range(1))
                item.page_addr = item.page_addr - $urandom_range(FL_PAGE_BYTES - 1, 1);
            item.range_end = win_base + (k + span) * FL_PAGE_BYTES - 1
                             + $urandom_range(FL_PAGE_BYTES);
        end
        else if (pick < 88)
        begin
            case ($urandom_range(2))
                0:       item.page_addr = $urandom;
                1:       item.page_addr = item.page_addr
                                          + $urandom_range(FL_PAGE_BYTES - 1, 1);
                default: item.page_addr = win_base + good_pages * FL_PAGE_BYTES;
            endcase
        end
        else if (pick < 93)
        begin
            item.action    = pfla_pkg::ACT_RANGE;
            item.page_addr = $urandom;
        end
        else if (pick < 96)
        begin
            item.action    = ACT_UNUSED;
            item.page_addr = $urandom;
        end
        else
        begin
            // Walks off the end of the window and stops at the first bad page.
            item.action    = pfla_pkg::ACT_RANGE;
            item.page_addr = win_base + (good_pages - $urandom_range(3)) * FL_PAGE_BYTES;
            item.range_end = item.page_addr + 8 * FL_PAGE_BYTES;
        end
        return item;
    endfunction

    task automatic test_alloc_free();
        reconfigure(32'h0, pfla_pkg::PHYS_TOP_RESET);
        send_beat(pfla_pkg::ACT_ALLOC, 32'h0, 32'h0);
        send_beat(pfla_pkg::ACT_FREE, 32'h0000_0000, 32'h0);
        send_beat(pfla_pkg::ACT_FREE, 32'h00FF_F000, 32'hFFFF_FFFF);
        send_beat(pfla_pkg::ACT_FREE, 32'h0000_1001, 32'h0);
        send_beat(pfla_pkg::ACT_FREE, 32'h0100_0000, 32'h0);
        send_beat(pfla_pkg::ACT_FREE, 32'hFFFF_FFFF, 32'h0);
        send_beat(pfla_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(pfla_pkg::ACT_ALLOC, 32'h0, 32'h0);
        send_beat(pfla_pkg::ACT_ALLOC, 32'h0, 32'h0);
    endtask

    task automatic test_range_walk();
        send_beat(pfla_pkg::ACT_RANGE, 32'h0000_0001, 32'h0000_3001);
        send_beat(pfla_pkg::ACT_RANGE, 32'h0000_5000, 32'h0000_4FFF);
        send_beat(pfla_pkg::ACT_RANGE, 32'hFFFF_F001, 32'hFFFF_FFFF);
        send_beat(pfla_pkg::ACT_RANGE, 32'h00FF_E000, 32'h0100_2000);
        // The whole physical memory, ending on the first page past phys_top.
        send_beat(pfla_pkg::ACT_RANGE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(pfla_pkg::ACT_ALLOC, 32'h0, 32'h0);
        send_beat(pfla_pkg::ACT_ALLOC, 32'h0, 32'h0);
    endtask

    task automatic test_unused_action();
        send_beat(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(ACT_UNUSED, 32'h0, 32'h0);
    endtask

    task automatic test_config_extremes();
        // With phys_top at zero every page is rejected.
        reconfigure(32'hFFFF_F000, 25'd0);
        send_beat(pfla_pkg::ACT_FREE, 32'hFFFF_F000, 32'h0);
        // A kernel base at the top makes physical addresses wrap around zero.
        reconfigure(32'hFFFF_F000, pfla_pkg::PHYS_TOP_RESET);
        send_beat(pfla_pkg::ACT_FREE, 32'hFFFF_F000, 32'h0);
        send_beat(pfla_pkg::ACT_FREE, 32'h0000_0000, 32'h0);
        send_beat(pfla_pkg::ACT_RANGE, 32'hFFFF_E000, 32'hFFFF_FFFF);
        send_beat(pfla_pkg::ACT_ALLOC, 32'h0, 32'h0);
        send_beat(pfla_pkg::ACT_ALLOC, 32'h0, 32'h0);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input int count, input logic [AW-1:0] base,
                                       input logic [TW-1:0] top);
        reconfigure(base, top);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_item(random_beat());
    endtask

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Every result beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        pfla_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %h", $time, out_item);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.result_addr !== want.result_addr)
                begin
                    $display("%0t: result_addr expected %h actual %h",
                             $time, want.result_addr, out_item.result_addr);
                    errors++;
                end
                if (out_item.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_item.status);
                    errors++;
                end
                if (out_item.pages_added !== want.pages_added)
                begin
                    $display("%0t: pages_added expected %0d actual %0d",
                             $time, want.pages_added, out_item.pages_added);
                    errors++;
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither side moves a beat.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("** page_free_list_allocator: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_item        = '0;
        out_stall      = 1'b0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        errors         = 0;
        quiet_cycles   = 0;
        n_beats        = 0;
        n_results      = 0;
        n_empty        = 0;
        n_bad          = 0;
        n_pushed       = 0;
        fl_head_valid  = 1'b0;
        fl_head_page   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alloc_free();
        test_range_walk();
        test_unused_action();
        test_config_extremes();
        test_random_traffic(0, 0, 440, 32'h0, pfla_pkg::PHYS_TOP_RESET);
        test_random_traffic(46, 0, 440, 32'hFFFF_F000, 25'h020_0000);
        test_random_traffic(0, 46, 440, $urandom & ~AW'(FL_PAGE_BYTES - 1),
                            TW'($urandom_range(16777216, 4096)));
        test_random_traffic(24, 24, 440, $urandom_range(32'hFFFF_F000),
                            TW'($urandom_range(16777216)));
        drain_results();

        $display("Run covered %0d beats and %0d results: %0d empty allocations, %0d bad pages,",
                 n_beats, n_results, n_empty, n_bad);
        $display("%0d pages pushed, four idle/stall phases, register values at both ends.",
                 n_pushed);
        if (errors == 0 && pending_results.size() == 0)
            $display("** page_free_list_allocator: PASSED **");
        else
            $display("** page_free_list_allocator: FAILED **");
        $finish;
    end

endmodule
